/* design/plcs_pkg.sv */
// Shared types and constants for the piecewise linear contrast stretch core.
// Used by the mapping-table builder, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package plcs_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W     = 8;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int LUT_DEPTH = 1 << PIX_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    // Register reset levels
    localparam logic [PIX_W-1:0] KNEE1_IN_RST  = 8'd85;
    localparam logic [PIX_W-1:0] KNEE1_OUT_RST = 8'd85;
    localparam logic [PIX_W-1:0] KNEE2_IN_RST  = 8'd170;
    localparam logic [PIX_W-1:0] KNEE2_OUT_RST = 8'd170;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNEE1_IN  = 8'd0,
        REG_KNEE1_OUT = 8'd1,
        REG_KNEE2_IN  = 8'd2,
        REG_KNEE2_OUT = 8'd3
    } plcs_reg_idx_t;

    // Breakpoint settings handed to the table builder
    typedef struct packed {
        logic [PIX_W-1:0] knee1_in;
        logic [PIX_W-1:0] knee1_out;
        logic [PIX_W-1:0] knee2_in;
        logic [PIX_W-1:0] knee2_out;
    } plcs_knees_t;

    // Write request from the table builder into the mapping table
    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] addr;
        logic [PIX_W-1:0] data;
    } plcs_lut_wr_t;

endpackage

`default_nettype wire

/* design/plcs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/plcs_div.sv */
// Restoring divider, one quotient bit per cycle, 8-bit quotient from a 16-bit dividend.
// Depends on plcs_pkg. Caller guarantees the quotient fits in PIX_W bits.
`timescale 1ns / 1ps
`default_nettype none

module plcs_div
    import plcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [PIX_W-1:0] den,
    output logic                  done,
    output logic      [PIX_W-1:0] quot
);

    localparam int CNT_W = $clog2(PIX_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIX_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PIX_W-1:0] rem_reg;
    logic [PIX_W-1:0] lo_reg;
    logic [PIX_W-1:0] den_reg;

    logic [PIX_W:0]   trial;
    logic [PIX_W-1:0] diff;
    logic             take;

    // Trial subtract of the shifted partial remainder; the difference fits in PIX_W bits
    always_comb
    begin
        trial = {rem_reg, lo_reg[PIX_W-1]};
        diff  = trial[PIX_W-1:0] - den_reg;
        take  = trial >= {1'b0, den_reg};
    end

    // Load on start, then step one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            lo_reg   <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            // The high half is already below the divisor when the quotient fits
            rem_reg  <= num[NUM_W-1:PIX_W];
            lo_reg   <= num[PIX_W-1:0];
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff : trial[PIX_W-1:0];
            lo_reg   <= {lo_reg[PIX_W-2:0], take};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

    // Done is a single-cycle pulse that follows the last step
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

/* design/plcs_build.sv */
// Mapping-table builder: walks all pixel levels, forms the segment fraction,
// divides it and writes the level's result into the table. Depends on plcs_pkg, plcs_div.
`timescale 1ns / 1ps
`default_nettype none

module plcs_build
    import plcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         restart,
    input  wire plcs_knees_t  knees,
    output logic              busy,
    output plcs_lut_wr_t      lut_wr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_START,
        S_WAIT
    } state_t;

    state_t           state_reg;
    logic [PIX_W-1:0] idx_reg;
    logic [NUM_W-1:0] prod_a_reg;
    logic [NUM_W-1:0] prod_b_reg;
    logic [PIX_W-1:0] den_reg;

    logic [PIX_W-1:0] ax, ay, bx, by, den_next;
    logic [NUM_W-1:0] prod_a_next, prod_b_next;
    logic [NUM_W-1:0] num_sum;
    logic             div_done;
    logic [PIX_W-1:0] div_quot;
    logic             div_start;

    // Pick the segment for the current level and its multiplier operands
    always_comb
    begin
        ax       = '0;
        ay       = '0;
        bx       = '0;
        by       = '0;
        den_next = 8'd1;
        priority if (idx_reg >= knees.knee2_in)
        begin
            if (knees.knee2_in == PIX_MAX)
            begin
                // Upper segment collapsed to the last level: result is the knee level
                ax       = knees.knee2_out;
                ay       = 8'd1;
                den_next = 8'd1;
            end
            else
            begin
                ax       = knees.knee2_out;
                ay       = PIX_MAX - idx_reg;
                bx       = PIX_MAX;
                by       = idx_reg - knees.knee2_in;
                den_next = PIX_MAX - knees.knee2_in;
            end
        end
        else if (idx_reg >= knees.knee1_in)
        begin
            ax       = knees.knee1_out;
            ay       = knees.knee2_in - idx_reg;
            bx       = knees.knee2_out;
            by       = idx_reg - knees.knee1_in;
            den_next = knees.knee2_in - knees.knee1_in;
        end
        else
        begin
            ax       = knees.knee1_out;
            ay       = idx_reg;
            den_next = knees.knee1_in;
        end
        prod_a_next = {{PIX_W{1'b0}}, ax} * {{PIX_W{1'b0}}, ay};
        prod_b_next = {{PIX_W{1'b0}}, bx} * {{PIX_W{1'b0}}, by};
    end

    // Weighted sum never exceeds 255*255, so 16 bits hold it exactly
    assign num_sum   = prod_a_reg + prod_b_reg;
    assign div_start = (state_reg == S_START);

    plcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_sum),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequence one level at a time; restart the sweep on any setting change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            idx_reg    <= '0;
            prod_a_reg <= '0;
            prod_b_reg <= '0;
            den_reg    <= 8'd1;
        end
        else if (restart)
        begin
            state_reg <= S_LOAD;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    state_reg <= S_IDLE;
                end
                S_LOAD:
                begin
                    prod_a_reg <= prod_a_next;
                    prod_b_reg <= prod_b_next;
                    den_reg    <= den_next;
                    state_reg  <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        if (idx_reg == PIX_MAX)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign lut_wr.we   = (state_reg == S_WAIT) && div_done && !restart;
    assign lut_wr.addr = idx_reg;
    assign lut_wr.data = div_quot;

    // The divisor loaded for a level is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START) |-> (den_reg != '0))
        else $error("zero divisor reached the divider");

endmodule

`default_nettype wire

/* design/piecewise_linear_contrast_stretch_core.sv */
// Top level of the piecewise linear contrast stretch: settings registers,
// mapping table memory and the pixel lookup pipeline. Depends on plcs_pkg,
// plcs_ram, plcs_build.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     pixel_in [7:0]
//   out      source     out_valid / out_ready   pixel_out [7:0]
//   cfg      sink       cfg_valid / cfg_ready   cfg_index [7:0], cfg_data [7:0]
//
// One pixel per cycle sustained while no rebuild runs and the output is not stalled;
// pixels pass the table read, then the output register. After reset and after each
// breakpoint register write the table is rebuilt, during which in_ready stays low.
// A stalled output holds the read stage; outside a rebuild in_ready drops only when
// both stages are full and out_ready is low. Settings writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_contrast_stretch_core
    import plcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PIX_W-1:0]     pixel_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [PIX_W-1:0]     pixel_out,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]     cfg_data
);

    plcs_knees_t      knees_reg;
    logic             cfg_hit;
    logic             build_busy;
    plcs_lut_wr_t     lut_wr;
    logic [PIX_W-1:0] lut_rdata;

    logic             in_accept;
    logic             move1;
    logic             s1_vld_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;

    assign cfg_ready = 1'b1;

    // Decode settings writes; unknown indexes are dropped
    always_comb
    begin
        unique case (cfg_index)
            REG_KNEE1_IN, REG_KNEE1_OUT, REG_KNEE2_IN, REG_KNEE2_OUT: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    // Hold breakpoint settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knees_reg.knee1_in  <= KNEE1_IN_RST;
            knees_reg.knee1_out <= KNEE1_OUT_RST;
            knees_reg.knee2_in  <= KNEE2_IN_RST;
            knees_reg.knee2_out <= KNEE2_OUT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KNEE1_IN:  knees_reg.knee1_in  <= cfg_data;
                REG_KNEE1_OUT: knees_reg.knee1_out <= cfg_data;
                REG_KNEE2_IN:  knees_reg.knee2_in  <= cfg_data;
                REG_KNEE2_OUT: knees_reg.knee2_out <= cfg_data;
                default:       knees_reg <= knees_reg;
            endcase
        end
    end

    plcs_build u_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_hit),
        .knees   (knees_reg),
        .busy    (build_busy),
        .lut_wr  (lut_wr)
    );

    // Pixel pipeline handshake: read stage, then output register
    assign move1     = s1_vld_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !build_busy && (!s1_vld_reg || move1);
    assign in_accept = in_valid && in_ready;

    plcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LUT_DEPTH)
    ) u_lut (
        .clk   (clk),
        .we    (lut_wr.we),
        .waddr (lut_wr.addr),
        .wdata (lut_wr.data),
        .re    (in_accept),
        .raddr (pixel_in),
        .rdata (lut_rdata)
    );

    // Advance the read stage into the output register, hold on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pixel_out_reg <= '0;
        end
        else
        begin
            s1_vld_reg    <= in_accept || (s1_vld_reg && !move1);
            out_valid_reg <= move1 || (out_valid_reg && !out_ready);
            if (move1)
            begin
                pixel_out_reg <= lut_rdata;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    // Table writes never meet a pixel read
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        lut_wr.we |-> !in_accept)
        else $error("table write overlapped a pixel request");

    // A settings write starts a rebuild at once
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> build_busy)
        else $error("settings write did not start a table rebuild");

    // A blocked read stage keeps its request and data
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !move1) |=> (s1_vld_reg && $stable(lut_rdata)))
        else $error("read stage lost a stalled request");

    // A new result only comes from a filled read stage
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && !s1_vld_reg |=> !out_valid_reg)
        else $error("result appeared without a request in the read stage");

endmodule

`default_nettype wire

/* verif/piecewise_linear_contrast_stretch_core_tb.sv */
// Self-checking bench for piecewise_linear_contrast_stretch_core: drives pixels under
// several breakpoint settings and compares each output against an integer line predictor.
// Depends on plcs_pkg and the core RTL.
`timescale 1ns / 1ps

module piecewise_linear_contrast_stretch_core_tb;

    import plcs_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int NUM_SETTINGS   = 14;
    localparam int PIXELS_PER_SET = 96;
    localparam int DRAIN_CYCLES   = 4;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel_in  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PIX_W-1:0]     cfg_data  = '0;

    // Shadow copy of the breakpoint registers
    plcs_knees_t knees = '{KNEE1_IN_RST, KNEE1_OUT_RST, KNEE2_IN_RST, KNEE2_OUT_RST};

    logic [PIX_W-1:0] pixel_queue[$];
    logic [PIX_W-1:0] expected_levels[$];
    logic [PIX_W-1:0] wanted_level;

    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned result_count   = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    piecewise_linear_contrast_stretch_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor of the exact three-segment line value for one gray level
    function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] p);
        int unsigned lvl, top, k1i, k1o, k2i, k2o, num, den;
        lvl = p;
        top = PIX_MAX;
        k1i = knees.knee1_in;
        k1o = knees.knee1_out;
        k2i = knees.knee2_in;
        k2o = knees.knee2_out;
        if (lvl >= k2i)
        begin
            den = top - k2i;
            if (den == 0)
                return knees.knee2_out;
            num = k2o * (top - lvl) + top * (lvl - k2i);
            return PIX_W'(num / den);
        end
        if (lvl >= k1i)
        begin
            den = k2i - k1i;
            num = k1o * (k2i - lvl) + k2o * (lvl - k1i);
            return PIX_W'(num / den);
        end
        return PIX_W'((k1o * lvl) / k1i);
    endfunction

    // Hold a register write request until taken, then update the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KNEE1_IN:  knees.knee1_in  = val;
            REG_KNEE1_OUT: knees.knee1_out = val;
            REG_KNEE2_IN:  knees.knee2_in  = val;
            REG_KNEE2_OUT: knees.knee2_out = val;
            default: ;
        endcase
    endtask

    // Wait until every queued pixel is taken and every result has come back
    task automatic drain_pixels();
        while (pixel_queue.size() != 0 || accepted_count != pushed_count
               || expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] p);
        pixel_queue.insert(pixel_queue.size(), p);
        pushed_count++;
    endtask

    // Pixel near a knee, at an extreme, or uniform
    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return knees.knee1_in + PIX_W'($urandom_range(4)) - PIX_W'(2);
        if (sel < 24)
            return knees.knee2_in + PIX_W'($urandom_range(4)) - PIX_W'(2);
        if (sel < 30)
            return ($urandom_range(1) != 0) ? PIX_MAX : '0;
        return PIX_W'($urandom_range(255));
    endfunction

    // Advance the pixel request when the current one is taken or none is pending
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                pixel_in <= pixel_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Randomly stall the result side
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on each accepted pixel, check each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_levels.insert(expected_levels.size(), stretch_level(pixel_in));
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_levels.size() == 0)
                begin
                    $display("%0t: unexpected pixel_out, expected none, got %0d",
                             $time, pixel_out);
                    error_count++;
                end
                else
                begin
                    wanted_level = expected_levels.pop_front();
                    if (pixel_out !== wanted_level)
                    begin
                        $display("%0t: pixel_out wrong, expected %0d, got %0d",
                                 $time, wanted_level, pixel_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("piecewise_linear_contrast_stretch_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        plcs_knees_t setting;
        plcs_reg_idx_t idx;
        logic [PIX_W-1:0] val;
        logic [PIX_W-1:0] directed[$];

        directed = '{8'd0, 8'd1, 8'd84, 8'd85, 8'd86, 8'd127, 8'd128, 8'd169,
                     8'd170, 8'd171, 8'd254, 8'd255, 8'h55, 8'hAA};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            // Pick the breakpoints: reset values first, then fixed corner cases, then random ones
            case (ph)
                1: setting = '{8'd0,   8'd0,   8'd255, 8'd255};
                2: setting = '{8'd0,   8'd255, 8'd255, 8'd0};
                3: setting = '{8'd255, 8'd255, 8'd0,   8'd0};
                4: setting = '{8'd200, 8'd30,  8'd50,  8'd220};
                5: setting = '{8'd100, 8'd50,  8'd100, 8'd200};
                6: setting = '{8'd1,   8'd255, 8'd254, 8'd0};
                7: setting = '{8'd255, 8'd0,   8'd255, 8'd255};
                default:
                begin
                    setting.knee1_in  = PIX_W'($urandom_range(255));
                    setting.knee1_out = PIX_W'($urandom_range(255));
                    setting.knee2_in  = PIX_W'($urandom_range(255));
                    setting.knee2_out = PIX_W'($urandom_range(255));
                    // Mostly ordered knees
                    if ($urandom_range(3) != 0 && setting.knee1_in > setting.knee2_in)
                    begin
                        val = setting.knee1_in;
                        setting.knee1_in = setting.knee2_in;
                        setting.knee2_in = val;
                    end
                end
            endcase

            // Reprogram while idle; an unused index goes first and must be dropped
            if (ph != 0)
            begin
                drain_pixels();
                if (ph == 1)
                    write_reg(8'hFF, 8'hFF);
                else
                    write_reg(CFG_IDX_W'($urandom_range(255, 4)),
                              PIX_W'($urandom_range(255)));
                for (int i = 0; i < 4; i++)
                begin
                    idx = plcs_reg_idx_t'((i + ph) % 4);
                    case (idx)
                        REG_KNEE1_IN:  val = setting.knee1_in;
                        REG_KNEE1_OUT: val = setting.knee1_out;
                        REG_KNEE2_IN:  val = setting.knee2_in;
                        default:       val = setting.knee2_out;
                    endcase
                    write_reg(idx, val);
                end
                cfg_valid <= 1'b0;
            end

            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 58;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase

            if (ph == 0)
                foreach (directed[i])
                    queue_pixel(directed[i]);
            for (int n = 0; n < PIXELS_PER_SET; n++)
                queue_pixel(pick_pixel());
        end

        drain_pixels();

        $display("Checked %0d pixels over %0d breakpoint settings, including reversed,",
                 result_count, NUM_SETTINGS);
        $display("coincident, zero and full-scale knees plus ignored register writes.");
        if (error_count == 0)
            $display("piecewise_linear_contrast_stretch_core: match");
        else
            $display("piecewise_linear_contrast_stretch_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/plcs_pkg.sv
design/plcs_ram.sv
design/plcs_div.sv
design/plcs_build.sv
design/piecewise_linear_contrast_stretch_core.sv
verif/piecewise_linear_contrast_stretch_core_tb.sv
